// ===== src/aet_pkg.sv =====
// shared types, constants and helpers for the arithmetic expression tokenizer
package aet_pkg;

    // source size bound and the saturation limit it implies
    localparam longint SOURCE_BYTES = 64'd65536;
    localparam logic [15:0] LIMIT = (SOURCE_BYTES - 64'd1 > 64'd65535) ? 16'hFFFF
                                                                       : 16'(SOURCE_BYTES - 64'd1);

    // token kinds
    localparam logic [2:0] KIND_LITERAL = 3'd0;
    localparam logic [2:0] KIND_IDENT   = 3'd1;
    localparam logic [2:0] KIND_PLUS    = 3'd2;
    localparam logic [2:0] KIND_MINUS   = 3'd3;
    localparam logic [2:0] KIND_STAR    = 3'd4;
    localparam logic [2:0] KIND_SLASH   = 3'd5;
    localparam logic [2:0] KIND_STOPTOK = 3'd6;
    localparam logic [2:0] KIND_END     = 3'd7;

    // most tokens one byte can cause
    localparam int BUNDLE_TOKENS = 3;
    localparam int BUNDLE_CNT_W  = $clog2(BUNDLE_TOKENS + 1);
    localparam int BUNDLE_SEL_W  = $clog2(BUNDLE_TOKENS);

    // bundle queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_LIT   = 2'd1,
        MODE_IDENT = 2'd2,
        MODE_STOP  = 2'd3
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       final_byte;
    } src_beat_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic        run_last;
    } tok_beat_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
    } token_t;

    typedef struct packed {
        token_t [BUNDLE_TOKENS-1:0] tok;
        logic [BUNDLE_CNT_W-1:0]    count;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // clamp a length or offset to the saturation limit
    function automatic logic [15:0] sat16(input logic [16:0] v);
        logic [15:0] r;
        if (v > {1'b0, LIMIT}) r = LIMIT;
        else                   r = v[15:0];
        return r;
    endfunction

endpackage

// ===== src/arith_expression_tokenizer.sv =====
// top level of the streaming arithmetic expression tokenizer
// Source bytes arrive one beat at a time on the src channel, final_byte marking
// the last byte of a text; tokens leave on the tok channel as kind, start offset
// and length, with run_last set on the last token caused by a given byte. Digit
// runs give literals, a letter followed by letters or digits gives an identifier,
// + - * / give one-character tokens, whitespace is skipped and any other byte
// gives a stop token after which bytes are ignored until the final byte, which
// flushes a pending token and adds an end token before the scanner returns to its
// reset state. Offsets and lengths saturate at the source-size bound. A byte is
// taken every cycle while the four-bundle queue has room; each byte causes zero
// to three tokens, and the back end moves one token per cycle through its output
// register while the receiver is ready, so bytes sustain one per cycle while the
// average number of tokens per byte stays at or below one, else one token per
// cycle. Tokens pass a queue entry, then the output register, after their byte.
module arith_expression_tokenizer
    import aet_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_ready,
    input  src_beat_t src_beat,
    output logic      tok_valid,
    input  logic      tok_ready,
    output tok_beat_t tok_beat
);

    logic          accept;
    logic          push;
    logic          pop;
    bundle_t       wr_bundle;
    bundle_t       head;
    queue_status_t status;

    // take a byte whenever the queue can hold its bundle
    assign src_ready = !status.full;
    assign accept    = src_valid && src_ready;

    // classify the byte and form its token bundle
    aet_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .beat   (src_beat),
        .push   (push),
        .bundle (wr_bundle)
    );

    // bundles wait here so that a stalled output does not stall the scanner at once
    aet_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_bundle (wr_bundle),
        .pop       (pop),
        .head      (head),
        .status    (status)
    );

    // serialise bundles into token beats
    aet_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .status    (status),
        .pop       (pop),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_beat  (tok_beat)
    );

    // an accepted byte that causes tokens always finds a free queue slot
    assert property (@(posedge clk) disable iff (!rst_n)
        status.full |-> !accept)
        else $error("byte accepted with the queue full");

endmodule

// ===== src/aet_front.sv =====
// front end: classifies each byte, tracks scan state and builds a token bundle
module aet_front
    import aet_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  src_beat_t     beat,
    output logic          push,
    output bundle_t       bundle
);

    scan_mode_t  mode_reg, mode_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] pstart_reg, pstart_next;

    logic [7:0]  c;
    logic        fin, is_num, is_letter, is_word, is_space, is_op;
    logic        flush_a, scan_idle, starts_lit, starts_ident, stop_hit;
    logic        lit_after, ident_after;
    logic [15:0] span, span_cur, pos_plus;
    logic [2:0]  op_kind;

    assign c         = beat.char_code;
    assign fin       = beat.final_byte;
    assign is_num    = (c >= "0") && (c <= "9");
    assign is_letter = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    assign is_word   = is_num || is_letter;
    assign is_space  = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B)
                    || (c == 8'h0C) || (c == 8'h0D);
    assign is_op     = (c == "+") || (c == "-") || (c == "*") || (c == "/");

    assign flush_a      = ((mode_reg == MODE_LIT) && !is_num)
                       || ((mode_reg == MODE_IDENT) && !is_word);
    assign scan_idle    = (mode_reg == MODE_IDLE) || flush_a;
    assign starts_lit   = scan_idle && is_num;
    assign starts_ident = scan_idle && is_letter;
    assign stop_hit     = scan_idle && !is_word && !is_space && !is_op;
    assign lit_after    = starts_lit || ((mode_reg == MODE_LIT) && is_num);
    assign ident_after  = starts_ident || ((mode_reg == MODE_IDENT) && is_word);

    assign span     = (pos_reg >= pstart_reg) ? (pos_reg - pstart_reg) : 16'd0;
    // a token started by this byte has no distance yet
    assign span_cur = (starts_lit || starts_ident) ? 16'd0 : span;
    assign pos_plus = sat16({1'b0, pos_reg} + 17'd1);

    always_comb
    begin
        unique case (c)
            "+":     op_kind = KIND_PLUS;
            "-":     op_kind = KIND_MINUS;
            "*":     op_kind = KIND_STAR;
            "/":     op_kind = KIND_SLASH;
            default: op_kind = KIND_STOPTOK;
        endcase
    end

    // next state
    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        pstart_next = pstart_reg;
        if (accept)
        begin
            if (fin)
            begin
                mode_next   = MODE_IDLE;
                pos_next    = 16'd0;
                pstart_next = 16'd0;
            end
            else
            begin
                pos_next = pos_plus;
                if (starts_lit || starts_ident) pstart_next = pos_reg;
                if (lit_after)                          mode_next = MODE_LIT;
                else if (ident_after)                   mode_next = MODE_IDENT;
                else if (stop_hit || mode_reg == MODE_STOP) mode_next = MODE_STOP;
                else                                    mode_next = MODE_IDLE;
            end
        end
    end

    // outputs: candidate tokens in emission order, packed to the front of the bundle
    always_comb
    begin
        token_t                  cand [4];
        logic [3:0]              cv;
        logic [BUNDLE_CNT_W-1:0] n;

        cand[0].kind   = (mode_reg == MODE_LIT) ? KIND_LITERAL : KIND_IDENT;
        cand[0].start  = pstart_reg;
        cand[0].length = sat16({1'b0, span});
        cv[0]          = flush_a;

        cand[1].kind   = op_kind;
        cand[1].start  = pos_reg;
        cand[1].length = 16'd1;
        cv[1]          = scan_idle && (is_op || stop_hit);

        cand[2].kind   = lit_after ? KIND_LITERAL : KIND_IDENT;
        cand[2].start  = (starts_lit || starts_ident) ? pos_reg : pstart_reg;
        cand[2].length = sat16({1'b0, span_cur} + 17'd1);
        cv[2]          = fin && (lit_after || ident_after);

        cand[3].kind   = KIND_END;
        cand[3].start  = pos_plus;
        cand[3].length = 16'd0;
        cv[3]          = fin;

        bundle = '0;
        n      = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (cv[i])
            begin
                bundle.tok[n[BUNDLE_SEL_W-1:0]] = cand[i];
                n = n + 1'b1;
            end
        end
        bundle.count = n;
        push         = accept && (n != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= 16'd0;
            pstart_reg <= 16'd0;
        end
        else
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            pstart_reg <= pstart_next;
        end
    end

    // stop mode is left only by the final byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_STOP && accept && !fin) |=> (mode_reg == MODE_STOP))
        else $error("stop mode left before the final byte");

    // a final byte always leaves an end token as the last of its bundle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && fin) |-> (push && bundle.tok[bundle.count - 1'b1].kind == KIND_END))
        else $error("final byte without trailing end token");

endmodule

// ===== src/aet_queue.sv =====
// short bundle queue between the front and back ends
module aet_queue
    import aet_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bundle_t       wr_bundle,
    input  logic          pop,
    output bundle_t       head,
    output queue_status_t status
);

    bundle_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]  count_reg, count_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        count_next = count_reg + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push) entry_reg[wr_ptr_reg] <= wr_bundle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !status.full)
        else $error("bundle queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !status.empty)
        else $error("bundle queue underflow");

endmodule

// ===== src/aet_back.sv =====
// back end: walks the head bundle a token a cycle, unless stalled, to output
module aet_back
    import aet_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  bundle_t       head,
    input  queue_status_t status,
    output logic          pop,
    output logic          tok_valid,
    input  logic          tok_ready,
    output tok_beat_t     tok_beat
);

    logic [BUNDLE_SEL_W-1:0] sel_reg, sel_next;
    logic                    valid_reg, valid_next;
    tok_beat_t               beat_reg, beat_next;
    logic                    load, last_of_bundle;
    token_t                  cur;

    assign load           = !status.empty && (!valid_reg || tok_ready);
    assign cur            = head.tok[sel_reg];
    assign last_of_bundle = (BUNDLE_CNT_W'(sel_reg) + 1'b1) == head.count;
    assign pop            = load && last_of_bundle;

    always_comb
    begin
        sel_next   = sel_reg;
        valid_next = valid_reg;
        beat_next  = beat_reg;
        if (load)
        begin
            valid_next             = 1'b1;
            beat_next.token_kind   = cur.kind;
            beat_next.token_start  = cur.start;
            beat_next.token_length = cur.length;
            beat_next.run_last     = last_of_bundle;
            sel_next               = last_of_bundle ? '0 : sel_reg + 1'b1;
        end
        else if (tok_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg   <= sel_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign tok_valid = valid_reg;
    assign tok_beat  = beat_reg;

    // part way through a bundle the bundle must still be at the head
    assert property (@(posedge clk) disable iff (!rst_n)
        (sel_reg != '0) |-> (!status.empty && BUNDLE_CNT_W'(sel_reg) < head.count))
        else $error("token index beyond head bundle");

    // a beat loaded before the last of its bundle leaves the walk mid-bundle
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && !last_of_bundle) |=> (sel_reg != '0))
        else $error("bundle walk lost its place");

endmodule

// ===== test/arith_expression_tokenizer_tb.sv =====
// self-checking testbench for the arithmetic expression tokenizer
module arith_expression_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aet_pkg::*;

    // character codes the scanner treats as operators
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // marks a table row whose tokens come from the scanner model below
    localparam int FROM_MODEL = -1;

    // random bytes (outside stopped mode) per idling phase
    localparam int PHASE_BYTES = 50;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      src_valid = 1'b0;
    logic      src_ready;
    src_beat_t src_beat  = '0;
    logic      tok_valid;
    logic      tok_ready = 1'b0;
    tok_beat_t tok_beat;

    arith_expression_tokenizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_beat  (src_beat),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_beat  (tok_beat)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // scanner model: its own copy of mode, pending start and position
    // ------------------------------------------------------------------
    scan_mode_t  scan_mode_m  = MODE_IDLE;
    logic [15:0] tok_start_m  = '0;
    logic [15:0] next_pos_m   = '0;

    // tokens still owed by the block, oldest first
    tok_beat_t   tokens_due[$];

    int          fails        = 0;
    int          tokens_seen  = 0;
    int          bytes_sent   = 0;
    int          live_bytes   = 0;   // bytes not swallowed by stopped mode
    int          texts_sent   = 0;

    // idling percentages, changed per phase
    int          src_gap_pct   = 0;
    int          rcv_stall_pct = 0;

    // clamp an offset or length at the saturation bound
    function automatic logic [15:0] clip_to_limit(input logic [16:0] v);
        logic [15:0] r;
        if (v > {1'b0, LIMIT})
        begin
            r = LIMIT;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic tok_beat_t tk(input logic [2:0] kind, input logic [15:0] start,
                                     input logic [15:0] len, input logic last);
        tok_beat_t t;
        t.token_kind   = kind;
        t.token_start  = start;
        t.token_length = len;
        t.run_last     = last;
        return t;
    endfunction

    // scan one accepted byte; queue its tokens when record is set
    function automatic void scan_byte(input logic [7:0] ch, input logic fin,
                                      input logic record);
        logic [15:0] pos;
        logic [16:0] span;
        logic        dig;
        logic        alp;
        logic        ws;
        tok_beat_t   out [0:2];
        int          n;

        pos  = next_pos_m;
        span = (pos >= tok_start_m) ? {1'b0, pos - tok_start_m} : 17'd0;
        dig  = (ch >= 8'h30) && (ch <= 8'h39);
        alp  = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
        ws   = (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
        n    = 0;

        if (scan_mode_m != MODE_STOP)
        begin
            live_bytes++;
        end

        // a pending token ends on a byte that cannot extend it
        if (scan_mode_m == MODE_LIT && !dig)
        begin
            out[n] = tk(KIND_LITERAL, tok_start_m, clip_to_limit(span), 1'b0);
            n = n + 1;
            scan_mode_m = MODE_IDLE;
        end
        else if (scan_mode_m == MODE_IDENT && !dig && !alp)
        begin
            out[n] = tk(KIND_IDENT, tok_start_m, clip_to_limit(span), 1'b0);
            n = n + 1;
            scan_mode_m = MODE_IDLE;
        end

        // the ending byte is then scanned afresh
        if (scan_mode_m == MODE_IDLE)
        begin
            if (dig)
            begin
                scan_mode_m = MODE_LIT;
                tok_start_m = pos;
            end
            else if (alp)
            begin
                scan_mode_m = MODE_IDENT;
                tok_start_m = pos;
            end
            else if (!ws)
            begin
                case (ch)
                    CH_PLUS:  out[n] = tk(KIND_PLUS, pos, 16'd1, 1'b0);
                    CH_MINUS: out[n] = tk(KIND_MINUS, pos, 16'd1, 1'b0);
                    CH_STAR:  out[n] = tk(KIND_STAR, pos, 16'd1, 1'b0);
                    CH_SLASH: out[n] = tk(KIND_SLASH, pos, 16'd1, 1'b0);
                    default:
                    begin
                        out[n] = tk(KIND_STOPTOK, pos, 16'd1, 1'b0);
                        scan_mode_m = MODE_STOP;
                    end
                endcase
                n = n + 1;
            end
        end

        if (fin)
        begin
            // the final byte counts towards a token it extends
            span = (pos >= tok_start_m) ? {1'b0, pos - tok_start_m} : 17'd0;
            if (scan_mode_m == MODE_LIT)
            begin
                out[n] = tk(KIND_LITERAL, tok_start_m, clip_to_limit(span + 17'd1), 1'b0);
                n = n + 1;
            end
            else if (scan_mode_m == MODE_IDENT)
            begin
                out[n] = tk(KIND_IDENT, tok_start_m, clip_to_limit(span + 17'd1), 1'b0);
                n = n + 1;
            end
            out[n] = tk(KIND_END, clip_to_limit({1'b0, pos} + 17'd1), 16'd0, 1'b0);
            n = n + 1;
            scan_mode_m = MODE_IDLE;
            tok_start_m = '0;
            next_pos_m  = '0;
        end
        else
        begin
            next_pos_m = clip_to_limit({1'b0, pos} + 17'd1);
        end

        if (record)
        begin
            for (int i = 0; i < n; i++)
            begin
                out[i].run_last = (i == n - 1);
                tokens_due.push_back(out[i]);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // source side: one byte per call, valid held until the beat is taken
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] ch, input logic fin, input logic record);
        // random gap before the beat, valid low throughout
        while ($urandom_range(99) < src_gap_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid           <= 1'b1;
        src_beat.char_code  <= ch;
        src_beat.final_byte <= fin;
        // inputs only move at the rising edge, so ready is settled at the falling one
        do
        begin
            @(negedge clk);
        end
        while (!src_ready);
        @(posedge clk);
        bytes_sent++;
        if (fin)
        begin
            texts_sent++;
        end
        scan_byte(ch, fin, record);
    endtask

    // one short well-formed text, with the odd arbitrary byte as noise
    task automatic push_random_text();
        int          len;
        int          pick;
        logic [7:0]  ch;
        logic [7:0]  ops [0:3];

        ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                ch = 8'($urandom_range(8'h39, 8'h30));
            end
            else if (pick < 58)
            begin
                ch = $urandom_range(1) ? 8'($urandom_range(8'h7A, 8'h61))
                                       : 8'($urandom_range(8'h5A, 8'h41));
            end
            else if (pick < 76)
            begin
                ch = ops[2'($urandom_range(3))];
            end
            else if (pick < 90)
            begin
                ch = $urandom_range(1) ? 8'h20 : 8'($urandom_range(8'h0D, 8'h09));
            end
            else
            begin
                ch = 8'($urandom_range(255));
            end
            push_byte(ch, i == len - 1, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // token side: random back-pressure and in-order checking
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        tok_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    // ready moves only at the rising edge, so a beat seen here is taken at the next one
    always @(negedge clk)
    begin
        tok_beat_t want;
        if (rst_n && tok_valid && tok_ready)
        begin
            tokens_seen++;
            if (tokens_due.size() == 0)
            begin
                fails++;
                $display("%0t: unexpected token: kind %0d start %0d length %0d last %0b",
                         $time, tok_beat.token_kind, tok_beat.token_start,
                         tok_beat.token_length, tok_beat.run_last);
            end
            else
            begin
                want = tokens_due.pop_front();
                if (tok_beat.token_kind !== want.token_kind
                    || tok_beat.token_start !== want.token_start
                    || tok_beat.token_length !== want.token_length
                    || tok_beat.run_last !== want.run_last)
                begin
                    fails++;
                    $display("%0t: token mismatch: expected kind %0d start %0d length %0d last %0b",
                             $time, want.token_kind, want.token_start, want.token_length,
                             want.run_last);
                    $display("%0t:                 actual   kind %0d start %0d length %0d last %0b",
                             $time, tok_beat.token_kind, tok_beat.token_start,
                             tok_beat.token_length, tok_beat.run_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // directed texts: tokens typed in where obvious, else from the model
    // ------------------------------------------------------------------
    typedef struct {
        logic [7:0] ch;
        logic       fin;
        int         n_typed;
        tok_beat_t  t0;
        tok_beat_t  t1;
    } dir_row_t;

    localparam int DIR_ROWS = 28;
    dir_row_t plan [0:DIR_ROWS-1];

    initial
    begin
        plan = '{
            // NUL straight after reset stops the scan, 0xFF is then swallowed
            '{8'h00, 1'b0, 1, tk(KIND_STOPTOK, 16'd0, 16'd1, 1'b1), '0},
            '{8'hFF, 1'b0, 0, '0, '0},
            // final byte while stopped gives only the end token
            '{8'h78, 1'b1, 1, tk(KIND_END, 16'd3, 16'd0, 1'b1), '0},
            // the four operators
            '{CH_PLUS,  1'b0, 1, tk(KIND_PLUS,  16'd0, 16'd1, 1'b1), '0},
            '{CH_MINUS, 1'b0, 1, tk(KIND_MINUS, 16'd1, 16'd1, 1'b1), '0},
            '{CH_STAR,  1'b0, 1, tk(KIND_STAR,  16'd2, 16'd1, 1'b1), '0},
            '{CH_SLASH, 1'b0, 1, tk(KIND_SLASH, 16'd3, 16'd1, 1'b1), '0},
            // space and tab skipped
            '{8'h20, 1'b0, 0, '0, '0},
            '{8'h09, 1'b0, 0, '0, '0},
            // literal "19" cut by a letter, identifier "Az0" cut by an operator
            '{8'h31, 1'b0, FROM_MODEL, '0, '0},
            '{8'h39, 1'b0, FROM_MODEL, '0, '0},
            '{8'h41, 1'b0, FROM_MODEL, '0, '0},
            '{8'h7A, 1'b0, FROM_MODEL, '0, '0},
            '{8'h30, 1'b0, FROM_MODEL, '0, '0},
            '{CH_PLUS, 1'b0, FROM_MODEL, '0, '0},
            // identifier cut by CR
            '{8'h5A, 1'b0, FROM_MODEL, '0, '0},
            '{8'h0D, 1'b0, FROM_MODEL, '0, '0},
            // literal flushed by a final operator: three tokens from one byte
            '{8'h35, 1'b0, FROM_MODEL, '0, '0},
            '{CH_SLASH, 1'b1, FROM_MODEL, '0, '0},
            // one-letter text: identifier then end
            '{8'h61, 1'b1, 2, tk(KIND_IDENT, 16'd0, 16'd1, 1'b0),
                              tk(KIND_END, 16'd0 + 16'd1, 16'd0, 1'b1)},
            // literal extended by the final byte
            '{8'h37, 1'b0, FROM_MODEL, '0, '0},
            '{8'h38, 1'b1, FROM_MODEL, '0, '0},
            // top-bit byte as a one-byte text
            '{8'h80, 1'b1, 2, tk(KIND_STOPTOK, 16'd0, 16'd1, 1'b0),
                              tk(KIND_END, 16'd1, 16'd0, 1'b1)},
            // LF, VT, FF skipped, then a stray byte and a final while stopped
            '{8'h0A, 1'b0, 0, '0, '0},
            '{8'h0B, 1'b0, 0, '0, '0},
            '{8'h0C, 1'b0, 0, '0, '0},
            '{8'h40, 1'b0, 1, tk(KIND_STOPTOK, 16'd3, 16'd1, 1'b1), '0},
            '{8'h32, 1'b1, 1, tk(KIND_END, 16'd5, 16'd0, 1'b1), '0}
        };
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int   live_goal;

        // reset held low from the start, released at a rising edge
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed texts under light source gaps and heavy back-pressure
        src_gap_pct   = 9;
        rcv_stall_pct = 77;
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            push_byte(plan[r].ch, plan[r].fin, plan[r].n_typed == FROM_MODEL);
            if (plan[r].n_typed > 0)
            begin
                tokens_due.push_back(plan[r].t0);
            end
            if (plan[r].n_typed > 1)
            begin
                tokens_due.push_back(plan[r].t1);
            end
        end

        // random texts in three idling phases
        live_goal = live_bytes;
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    src_gap_pct   = 9;
                    rcv_stall_pct = 77;
                end
                1:
                begin
                    src_gap_pct   = 77;
                    rcv_stall_pct = 9;
                end
                default:
                begin
                    src_gap_pct   = 0;
                    rcv_stall_pct = 0;
                end
            endcase
            live_goal += PHASE_BYTES;
            while (live_bytes < live_goal)
            begin
                push_random_text();
            end
        end
        src_valid <= 1'b0;

        // drain, then allow for anything the block still emits
        while (tokens_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("covered %0d texts, %0d bytes (%0d outside stopped mode), %0d tokens checked",
                 texts_sent, bytes_sent, live_bytes, tokens_seen);
        if (fails == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog: several times the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
